// ===== rtl/jts_pkg.sv =====
// Shared types and constants of the JSON token scanner.
// Holds the token codes, the byte and token word layouts and the queue entry type.
package jts_pkg;

    localparam int LINE_FIELD_BITS   = 16;
    localparam int COLUMN_FIELD_BITS = 16;
    localparam int OFFSET_FIELD_BITS = 24;

    localparam logic [LINE_FIELD_BITS-1:0]   LINE_FIELD_MAX   = '1;
    localparam logic [COLUMN_FIELD_BITS-1:0] COLUMN_FIELD_MAX = '1;
    localparam logic [OFFSET_FIELD_BITS-1:0] OFFSET_FIELD_MAX = '1;

    localparam logic [3:0] KIND_END          = 4'd0;
    localparam logic [3:0] KIND_COMMA        = 4'd1;
    localparam logic [3:0] KIND_COLON        = 4'd2;
    localparam logic [3:0] KIND_LBRACKET     = 4'd3;
    localparam logic [3:0] KIND_RBRACKET     = 4'd4;
    localparam logic [3:0] KIND_LBRACE       = 4'd5;
    localparam logic [3:0] KIND_RBRACE       = 4'd6;
    localparam logic [3:0] KIND_INT          = 4'd7;
    localparam logic [3:0] KIND_STRING       = 4'd8;
    localparam logic [3:0] KIND_FALSE        = 4'd9;
    localparam logic [3:0] KIND_TRUE         = 4'd10;
    localparam logic [3:0] KIND_UNTERMINATED = 4'd11;
    localparam logic [3:0] KIND_UNEXPECTED   = 4'd12;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] source_byte;
    } byte_t;

    typedef struct packed {
        logic [3:0]                   token_kind;
        logic [LINE_FIELD_BITS-1:0]   start_line;
        logic [COLUMN_FIELD_BITS-1:0] start_column;
        logic [OFFSET_FIELD_BITS-1:0] start_offset;
        logic [OFFSET_FIELD_BITS-1:0] token_length;
        logic [7:0]                   error_char;
        logic                         last_of_run;
    } token_t;

    typedef struct packed {
        logic   pair;
        token_t first;
        token_t second;
    } entry_t;

endpackage

// ===== rtl/jts_stream_if.sv =====
// Valid/ready stream channel used for both the byte input and the token output.
// The payload type is set per instance; depends on nothing else.
interface jts_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/jts_front.sv =====
// Front part of the scanner: accepts source bytes, runs the mode machine and counters,
// and pushes the one or two tokens a byte may cause into the queue. Depends on jts_pkg and jts_stream_if.
module jts_front #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    jts_stream_if.sink      chars,
    input  logic            queue_full,
    output logic            push,
    output jts_pkg::entry_t push_entry
);
    import jts_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_INT     = 3'd1;
    localparam logic [2:0] M_STR     = 3'd2;
    localparam logic [2:0] M_KW      = 3'd3;
    localparam logic [2:0] M_DISCARD = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    logic [2:0]             mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [OFFSET_BITS-1:0] tok_off_reg, tok_off_next;
    logic [OFFSET_BITS-1:0] tok_len_reg, tok_len_next;
    logic                   kw_sel_reg, kw_sel_next;
    logic [2:0]             kw_prog_reg, kw_prog_next;
    logic [7:0]             first_reg, first_next;

    logic [7:0]             b;
    logic                   accept;
    logic                   phase2, adv, restart_doc;
    logic                   e1, e2;
    logic [3:0]             e1_kind, e2_kind;
    logic [OFFSET_BITS-1:0] e1_off, e1_len, e2_len;
    logic [7:0]             e1_char, e2_char;
    logic [2:0]             kw_len;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] kw_letter(input logic sel, input logic [2:0] prog);
        logic [7:0] c;
        c = CH_NUL;
        case ({sel, prog})
            4'b0001: c = "a";
            4'b0010: c = "l";
            4'b0011: c = "s";
            4'b0100: c = "e";
            4'b1001: c = "r";
            4'b1010: c = "u";
            4'b1011: c = "e";
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] inc_col(input logic [COLUMN_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_FIELD_BITS-1:0] clamp_line(input logic [LINE_BITS-1:0] v);
        return (LINE_BITS > LINE_FIELD_BITS && v > LINE_BITS'(LINE_FIELD_MAX)) ?
               LINE_FIELD_MAX : LINE_FIELD_BITS'(v);
    endfunction

    function automatic logic [COLUMN_FIELD_BITS-1:0] clamp_col(
        input logic [COLUMN_BITS-1:0] v);
        return (COLUMN_BITS > COLUMN_FIELD_BITS && v > COLUMN_BITS'(COLUMN_FIELD_MAX)) ?
               COLUMN_FIELD_MAX : COLUMN_FIELD_BITS'(v);
    endfunction

    function automatic logic [OFFSET_FIELD_BITS-1:0] clamp_off(
        input logic [OFFSET_BITS-1:0] v);
        return (OFFSET_BITS > OFFSET_FIELD_BITS && v > OFFSET_BITS'(OFFSET_FIELD_MAX)) ?
               OFFSET_FIELD_MAX : OFFSET_FIELD_BITS'(v);
    endfunction

    assign b = chars.data.source_byte;
    assign chars.ready = !queue_full;
    assign accept = chars.valid && !queue_full;
    assign kw_len = kw_sel_reg ? 3'd4 : 3'd5;

    always_comb
    begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        off_next      = off_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        tok_len_next  = tok_len_reg;
        kw_sel_next   = kw_sel_reg;
        kw_prog_next  = kw_prog_reg;
        first_next    = first_reg;
        phase2        = 1'b0;
        adv           = 1'b0;
        restart_doc   = 1'b0;
        e1            = 1'b0;
        e1_kind       = KIND_END;
        e1_off        = tok_off_reg;
        e1_len        = '0;
        e1_char       = CH_NUL;
        e2            = 1'b0;
        e2_kind       = KIND_END;
        e2_len        = '0;
        e2_char       = CH_NUL;

        unique case (mode_reg)
            M_DISCARD:
            begin
                if (b == CH_NUL)
                begin
                    restart_doc = 1'b1;
                end
            end
            M_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    e1        = 1'b1;
                    e1_kind   = KIND_STRING;
                    e1_off    = inc_off(tok_off_reg);
                    e1_len    = tok_len_reg;
                    adv       = 1'b1;
                    mode_next = M_IDLE;
                end
                else if (b == CH_NUL)
                begin
                    e1          = 1'b1;
                    e1_kind     = KIND_UNTERMINATED;
                    restart_doc = 1'b1;
                end
                else
                begin
                    tok_len_next = inc_off(tok_len_reg);
                    adv          = 1'b1;
                end
            end
            M_INT:
            begin
                if (is_digit(b))
                begin
                    tok_len_next = inc_off(tok_len_reg);
                    adv          = 1'b1;
                end
                else if (is_word(b))
                begin
                    e1        = 1'b1;
                    e1_kind   = KIND_UNEXPECTED;
                    e1_char   = first_reg;
                    mode_next = M_DISCARD;
                end
                else
                begin
                    e1      = 1'b1;
                    e1_kind = KIND_INT;
                    e1_len  = tok_len_reg;
                    phase2  = 1'b1;
                end
            end
            M_KW:
            begin
                if (kw_prog_reg < kw_len)
                begin
                    if (b == kw_letter(kw_sel_reg, kw_prog_reg))
                    begin
                        kw_prog_next = kw_prog_reg + 3'd1;
                        tok_len_next = inc_off(tok_len_reg);
                        adv          = 1'b1;
                    end
                    else
                    begin
                        e1      = 1'b1;
                        e1_kind = KIND_UNEXPECTED;
                        e1_char = first_reg;
                        if (b == CH_NUL)
                        begin
                            restart_doc = 1'b1;
                        end
                        else
                        begin
                            mode_next = M_DISCARD;
                        end
                    end
                end
                else if (is_word(b))
                begin
                    e1        = 1'b1;
                    e1_kind   = KIND_UNEXPECTED;
                    e1_char   = first_reg;
                    mode_next = M_DISCARD;
                end
                else
                begin
                    e1           = 1'b1;
                    e1_kind      = kw_sel_reg ? KIND_TRUE : KIND_FALSE;
                    e1_len       = tok_len_reg;
                    kw_prog_next = 3'd0;
                    phase2       = 1'b1;
                end
            end
            default:
            begin
                phase2 = 1'b1;
            end
        endcase

        if (phase2)
        begin
            mode_next = M_IDLE;
            if (is_space(b))
            begin
                adv = 1'b1;
            end
            else if (b == CH_NUL)
            begin
                e2          = 1'b1;
                e2_kind     = KIND_END;
                e2_len      = OFFSET_BITS'(1);
                restart_doc = 1'b1;
            end
            else if (b == "," || b == ":" || b == "[" || b == "]" || b == "{" || b == "}")
            begin
                e2     = 1'b1;
                e2_len = OFFSET_BITS'(1);
                adv    = 1'b1;
                case (b)
                    ",":     e2_kind = KIND_COMMA;
                    ":":     e2_kind = KIND_COLON;
                    "[":     e2_kind = KIND_LBRACKET;
                    "]":     e2_kind = KIND_RBRACKET;
                    "{":     e2_kind = KIND_LBRACE;
                    default: e2_kind = KIND_RBRACE;
                endcase
            end
            else if (is_digit(b) || b == CH_QUOTE || b == "f" || b == "t")
            begin
                tok_line_next = line_reg;
                tok_col_next  = col_reg;
                tok_off_next  = off_reg;
                tok_len_next  = OFFSET_BITS'(1);
                first_next    = b;
                adv           = 1'b1;
                if (is_digit(b))
                begin
                    mode_next = M_INT;
                end
                else if (b == CH_QUOTE)
                begin
                    tok_len_next = '0;
                    mode_next    = M_STR;
                end
                else
                begin
                    kw_sel_next  = (b == "t");
                    kw_prog_next = 3'd1;
                    mode_next    = M_KW;
                end
            end
            else
            begin
                e2        = 1'b1;
                e2_kind   = KIND_UNEXPECTED;
                e2_char   = (b >= 8'h20 && b <= 8'h7E) ? b : CH_QMARK;
                mode_next = M_DISCARD;
            end
        end

        if (adv)
        begin
            if (b == CH_LF)
            begin
                line_next = inc_line(line_reg);
                col_next  = COLUMN_BITS'(1);
            end
            else
            begin
                col_next = inc_col(col_reg);
            end
            off_next = inc_off(off_reg);
        end

        if (restart_doc)
        begin
            line_next    = LINE_BITS'(1);
            col_next     = COLUMN_BITS'(1);
            off_next     = '0;
            mode_next    = M_IDLE;
            kw_sel_next  = 1'b0;
            kw_prog_next = 3'd0;
        end
    end

    always_comb
    begin
        token_t t1, t2;
        t1.token_kind   = e1_kind;
        t1.start_line   = clamp_line(tok_line_reg);
        t1.start_column = clamp_col(tok_col_reg);
        t1.start_offset = clamp_off(e1_off);
        t1.token_length = clamp_off(e1_len);
        t1.error_char   = e1_char;
        t1.last_of_run  = !e2;
        t2.token_kind   = e2_kind;
        t2.start_line   = clamp_line(line_reg);
        t2.start_column = clamp_col(col_reg);
        t2.start_offset = clamp_off(off_reg);
        t2.token_length = clamp_off(e2_len);
        t2.error_char   = e2_char;
        t2.last_of_run  = 1'b1;
        push_entry.pair   = e1 && e2;
        push_entry.first  = e1 ? t1 : t2;
        push_entry.second = t2;
    end

    assign push = accept && (e1 || e2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            line_reg     <= LINE_BITS'(1);
            col_reg      <= COLUMN_BITS'(1);
            off_reg      <= '0;
            tok_line_reg <= LINE_BITS'(1);
            tok_col_reg  <= COLUMN_BITS'(1);
            tok_off_reg  <= '0;
            tok_len_reg  <= '0;
            kw_sel_reg   <= 1'b0;
            kw_prog_reg  <= 3'd0;
            first_reg    <= CH_NUL;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            off_reg      <= off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
            tok_len_reg  <= tok_len_next;
            kw_sel_reg   <= kw_sel_next;
            kw_prog_reg  <= kw_prog_next;
            first_reg    <= first_next;
        end
    end

endmodule

// ===== rtl/jts_queue.sv =====
// Short queue between the scanner front and the token back end.
// Each entry holds the tokens caused by one source byte. Depends on jts_pkg.
module jts_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jts_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            empty,
    output logic            full,
    output jts_pkg::entry_t head
);
    import jts_pkg::*;

    localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    entry_t                entries_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a write");

endmodule

// ===== rtl/jts_back.sv =====
// Back end of the scanner: takes queue entries and sends their tokens one per cycle
// while tokens.ready allows, through a registered output stage. Depends on jts_pkg and jts_stream_if.
module jts_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  jts_pkg::entry_t head,
    output logic            pop,
    jts_stream_if.source    tokens
);
    import jts_pkg::*;

    logic   out_valid_reg, out_valid_next;
    logic   sel_reg, sel_next;
    token_t out_data_reg, out_data_next;
    logic   load;

    assign load = !out_valid_reg || tokens.ready;
    assign pop  = load && !empty && (!head.pair || sel_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                out_data_next = sel_reg ? head.second : head.first;
                sel_next      = head.pair && !sel_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign tokens.valid = out_valid_reg;
    assign tokens.data  = out_data_reg;

endmodule

// ===== rtl/json_token_scanner.sv =====
// Top level of the JSON token scanner: front scanner, entry queue and token back end.
// Depends on jts_pkg, jts_stream_if, jts_front, jts_queue and jts_back.

// The scanner takes one source byte per cycle on chars while the queue is not full and
// sends tokens on tokens, one token per cycle while tokens.ready is high. Most bytes give
// no token or one; a byte that ends an integer or keyword and is itself a mark, the end
// byte or a stray character gives two, sent one after the other. A four-entry queue
// between the byte scanner and the output register absorbs these bursts, so bytes keep
// flowing while a token waits to be taken; chars.ready drops only when the queue is
// full. Each token passes through the queue and then the output register. Line, column
// and offset counters are LINE_BITS, COLUMN_BITS and OFFSET_BITS wide and saturate;
// token fields saturate at 16, 16 and 24 bits.
module json_token_scanner #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    jts_stream_if.sink   chars,
    jts_stream_if.source tokens
);
    import jts_pkg::*;

    logic   push, pop, empty, full;
    entry_t push_entry, head;

    jts_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    jts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .empty      (empty),
        .full       (full),
        .head       (head)
    );

    jts_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

// ===== bench/json_token_scanner_tb.sv =====
// Self-checking bench for json_token_scanner: JSON-like byte streams go in on chars and
// every token word on tokens is checked against a scanner model kept inside the bench.
// Depends on jts_pkg, jts_stream_if and the json_token_scanner RTL.
module json_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jts_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_STRING,
        SCAN_KEYWORD,
        SCAN_SKIP
    } scan_mode_e;

    localparam logic [7:0] CH_ZERO       = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_VTAB       = 8'h0B;
    localparam logic [7:0] CH_FEED       = 8'h0C;
    localparam logic [7:0] CH_RETURN     = 8'h0D;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_QMARK      = 8'h3F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam int RANDOM_BYTES      = 1100;
    localparam int HOLD_AFTER_TOKENS = 120;
    localparam int HOLD_CYCLES       = 300;
    localparam int DRAIN_CYCLES      = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b1;

    jts_stream_if #(.payload_t(byte_t))  byte_ch ();
    jts_stream_if #(.payload_t(token_t)) token_ch ();

    json_token_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (byte_ch),
        .tokens (token_ch)
    );

    logic [7:0]  src_bytes[$];
    token_t      expected_tokens[$];
    token_t      run_tokens[$];

    int          total_bytes;
    int          bytes_sent     = 0;
    int          tokens_checked = 0;
    int          mismatches     = 0;
    int          scanner_errors = 0;
    logic [12:0] kinds_seen     = '0;
    int          hold_left;
    bit          hold_done;
    logic        quiet;

    scan_mode_e  sc_mode;
    logic [15:0] sc_line;
    logic [15:0] sc_column;
    logic [23:0] sc_offset;
    logic [15:0] tk_line;
    logic [15:0] tk_column;
    logic [23:0] tk_offset;
    logic [23:0] tk_length;
    bit          kw_is_true;
    logic [2:0]  kw_pos;
    logic [7:0]  tk_first;

    assign quiet = (bytes_sent >= 500) && (bytes_sent < 750);

    always #5 clk = ~clk;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [23:0] inc24(input logic [23:0] v);
        return (v == 24'hFFFFFF) ? v : v + 24'd1;
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return (b == " ") || ((b >= CH_TAB) && (b <= CH_RETURN));
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic bit is_word(input logic [7:0] b);
        return is_digit(b) || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
            || (b == CH_UNDERSCORE);
    endfunction

    function automatic logic [7:0] kw_letter(input bit sel, input logic [2:0] pos);
        string w;
        if (sel)
            w = "true";
        else
            w = "false";
        return w[pos];
    endfunction

    function automatic string show(input token_t t);
        return $sformatf("kind %0d line %0d col %0d off %0d len %0d char %02h last %0b",
            t.token_kind, t.start_line, t.start_column, t.start_offset, t.token_length,
            t.error_char, t.last_of_run);
    endfunction

    task automatic add_token(input logic [3:0] kind, input logic [15:0] ln,
                             input logic [15:0] col, input logic [23:0] off,
                             input logic [23:0] len, input logic [7:0] ch);
        token_t t;
        t.token_kind   = kind;
        t.start_line   = ln;
        t.start_column = col;
        t.start_offset = off;
        t.token_length = len;
        t.error_char   = ch;
        t.last_of_run  = 1'b0;
        run_tokens.push_back(t);
    endtask

    task automatic step_counters(input logic [7:0] b);
        if (b == CH_NEWLINE)
        begin
            sc_line   = inc16(sc_line);
            sc_column = 16'd1;
        end
        else
        begin
            sc_column = inc16(sc_column);
        end
        sc_offset = inc24(sc_offset);
    endtask

    task automatic restart_doc();
        sc_line    = 16'd1;
        sc_column  = 16'd1;
        sc_offset  = 24'd0;
        sc_mode    = SCAN_IDLE;
        kw_is_true = 1'b0;
        kw_pos     = 3'd0;
    endtask

    task automatic open_token();
        tk_line   = sc_line;
        tk_column = sc_column;
        tk_offset = sc_offset;
        tk_length = 24'd1;
    endtask

    task automatic flag_token_error(input logic [7:0] b);
        add_token(KIND_UNEXPECTED, tk_line, tk_column, tk_offset, 24'd0, tk_first);
        if (b == CH_ZERO)
            restart_doc();
        else
            sc_mode = SCAN_SKIP;
    endtask

    task automatic scan_byte(input logic [7:0] b);
        logic [2:0] kw_len;
        logic [3:0] mark;
        bit         was_skip;
        bit         fresh;
        token_t     t;
        run_tokens.delete();
        was_skip = (sc_mode == SCAN_SKIP);
        case (sc_mode)
            SCAN_SKIP:
            begin
                if (b == CH_ZERO)
                    restart_doc();
            end
            SCAN_STRING:
            begin
                if (b == CH_QUOTE)
                begin
                    add_token(KIND_STRING, tk_line, tk_column, inc24(tk_offset), tk_length,
                        CH_ZERO);
                    step_counters(b);
                    sc_mode = SCAN_IDLE;
                end
                else if (b == CH_ZERO)
                begin
                    add_token(KIND_UNTERMINATED, tk_line, tk_column, tk_offset, 24'd0,
                        CH_ZERO);
                    restart_doc();
                end
                else
                begin
                    tk_length = inc24(tk_length);
                    step_counters(b);
                end
            end
            SCAN_INT:
            begin
                if (is_digit(b))
                begin
                    tk_length = inc24(tk_length);
                    step_counters(b);
                end
                else if (is_word(b))
                begin
                    flag_token_error(b);
                end
                else
                begin
                    add_token(KIND_INT, tk_line, tk_column, tk_offset, tk_length, CH_ZERO);
                    sc_mode = SCAN_IDLE;
                end
            end
            SCAN_KEYWORD:
            begin
                kw_len = kw_is_true ? 3'd4 : 3'd5;
                if (kw_pos < kw_len)
                begin
                    if (b == kw_letter(kw_is_true, kw_pos))
                    begin
                        kw_pos    = kw_pos + 3'd1;
                        tk_length = inc24(tk_length);
                        step_counters(b);
                    end
                    else
                    begin
                        flag_token_error(b);
                    end
                end
                else if (is_word(b))
                begin
                    flag_token_error(b);
                end
                else
                begin
                    add_token(kw_is_true ? KIND_TRUE : KIND_FALSE, tk_line, tk_column,
                        tk_offset, tk_length, CH_ZERO);
                    sc_mode = SCAN_IDLE;
                    kw_pos  = 3'd0;
                end
            end
            default:
            begin
                sc_mode = SCAN_IDLE;
            end
        endcase

        fresh = !was_skip && (sc_mode == SCAN_IDLE) && ((run_tokens.size() == 0)
            || ((run_tokens.size() == 1) && ((run_tokens[0].token_kind == KIND_INT)
            || (run_tokens[0].token_kind == KIND_FALSE)
            || (run_tokens[0].token_kind == KIND_TRUE))));

        if (fresh)
        begin
            if (is_space(b))
            begin
                step_counters(b);
            end
            else if (b == CH_ZERO)
            begin
                add_token(KIND_END, sc_line, sc_column, sc_offset, 24'd1, CH_ZERO);
                restart_doc();
            end
            else if ((b == ",") || (b == ":") || (b == "[") || (b == "]") || (b == "{")
                || (b == "}"))
            begin
                case (b)
                    ",":     mark = KIND_COMMA;
                    ":":     mark = KIND_COLON;
                    "[":     mark = KIND_LBRACKET;
                    "]":     mark = KIND_RBRACKET;
                    "{":     mark = KIND_LBRACE;
                    default: mark = KIND_RBRACE;
                endcase
                add_token(mark, sc_line, sc_column, sc_offset, 24'd1, CH_ZERO);
                step_counters(b);
            end
            else if (is_digit(b))
            begin
                open_token();
                tk_first = b;
                sc_mode  = SCAN_INT;
                step_counters(b);
            end
            else if (b == CH_QUOTE)
            begin
                open_token();
                tk_length = 24'd0;
                tk_first  = b;
                sc_mode   = SCAN_STRING;
                step_counters(b);
            end
            else if ((b == "f") || (b == "t"))
            begin
                open_token();
                tk_first   = b;
                kw_is_true = (b == "t");
                kw_pos     = 3'd1;
                sc_mode    = SCAN_KEYWORD;
                step_counters(b);
            end
            else
            begin
                add_token(KIND_UNEXPECTED, sc_line, sc_column, sc_offset, 24'd0,
                    ((b >= 8'h20) && (b <= 8'h7E)) ? b : CH_QMARK);
                sc_mode = SCAN_SKIP;
            end
        end

        foreach (run_tokens[i])
        begin
            t = run_tokens[i];
            t.last_of_run = (i == run_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            src_bytes.push_back(s[i]);
    endtask

    task automatic put_blank();
        int n;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0:       src_bytes.push_back(CH_NEWLINE);
                1:       src_bytes.push_back(CH_TAB);
                2:       src_bytes.push_back(CH_RETURN);
                3:       src_bytes.push_back(CH_VTAB);
                4:       src_bytes.push_back(CH_FEED);
                default: src_bytes.push_back(" ");
            endcase
        end
    endtask

    task automatic put_digits(input int n);
        repeat (n)
            src_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_string(input int n, input bit closed);
        logic [7:0] c;
        src_bytes.push_back(CH_QUOTE);
        repeat (n)
        begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_QUOTE)
                c = "x";
            src_bytes.push_back(c);
        end
        if (closed)
            src_bytes.push_back(CH_QUOTE);
    endtask

    task automatic put_value(input int depth);
        int n;
        case ($urandom_range(0, (depth < 2) ? 7 : 5))
            0, 1: put_digits($urandom_range(1, 4));
            2, 3: put_string($urandom_range(0, 5), 1'b1);
            4:    put_text("true");
            5:    put_text("false");
            6:
            begin
                src_bytes.push_back("[");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i != 0)
                        src_bytes.push_back(",");
                    put_blank();
                    put_value(depth + 1);
                    put_blank();
                end
                src_bytes.push_back("]");
            end
            default:
            begin
                src_bytes.push_back("{");
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                begin
                    if (i != 0)
                        src_bytes.push_back(",");
                    put_blank();
                    put_string($urandom_range(0, 4), 1'b1);
                    put_blank();
                    src_bytes.push_back(":");
                    put_blank();
                    put_value(depth + 1);
                    put_blank();
                end
                src_bytes.push_back("}");
            end
        endcase
    endtask

    task automatic put_document();
        put_blank();
        put_value(0);
        if ($urandom_range(0, 3) == 0)
        begin
            src_bytes.push_back(":");
            put_value(1);
        end
        put_blank();
        src_bytes.push_back(CH_ZERO);
    endtask

    task automatic put_broken();
        string w;
        int    n;
        case ($urandom_range(0, 5))
            0:
            begin
                repeat ($urandom_range(1, 6))
                    src_bytes.push_back(8'($urandom_range(1, 255)));
            end
            1:
            begin
                if ($urandom_range(0, 1))
                    w = "false";
                else
                    w = "true";
                n = $urandom_range(1, w.len() - 1);
                put_text(w.substr(0, n - 1));
                if ($urandom_range(0, 1))
                    src_bytes.push_back(8'($urandom_range(1, 255)));
            end
            2:
            begin
                case ($urandom_range(0, 2))
                    0:       put_digits($urandom_range(1, 3));
                    1:       put_text("true");
                    default: put_text("false");
                endcase
                case ($urandom_range(0, 2))
                    0:       src_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
                    1:       src_bytes.push_back(8'h41 + 8'($urandom_range(0, 25)));
                    default: src_bytes.push_back(CH_UNDERSCORE);
                endcase
                put_value(1);
            end
            3:
            begin
                put_string($urandom_range(0, 4), 1'b0);
            end
            4:
            begin
                case ($urandom_range(0, 2))
                    0:       put_digits($urandom_range(1, 3));
                    1:       put_text("true");
                    default: put_text("false");
                endcase
            end
            default:
            begin
                src_bytes.push_back(8'($urandom_range(1, 255)));
                put_value(1);
            end
        endcase
        src_bytes.push_back(CH_ZERO);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.data  <= '0;
            bytes_sent    <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                bytes_sent <= bytes_sent + 1;
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if ((src_bytes.size() != 0) && (quiet || ($urandom_range(0, 99) >= 11)))
                begin
                    byte_ch.data.source_byte <= src_bytes.pop_front();
                    byte_ch.valid            <= 1'b1;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : token_watch
        token_t want;
        if (!rst_n)
        begin
            token_ch.ready <= 1'b0;
            hold_left      <= 0;
            hold_done      <= 1'b0;
            restart_doc();
            tk_line   = 16'd1;
            tk_column = 16'd1;
            tk_offset = 24'd0;
            tk_length = 24'd0;
            tk_first  = CH_ZERO;
        end
        else
        begin
            if (token_ch.valid && token_ch.ready)
            begin
                tokens_checked++;
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: token word with none expected, got %s", $time,
                        show(token_ch.data));
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (want.token_kind <= KIND_UNEXPECTED)
                        kinds_seen[want.token_kind] = 1'b1;
                    if ((want.token_kind == KIND_UNTERMINATED)
                        || (want.token_kind == KIND_UNEXPECTED))
                        scanner_errors++;
                    if (token_ch.data !== want)
                    begin
                        mismatches++;
                        $display("%0t: token mismatch, expected %s, got %s", $time,
                            show(want), show(token_ch.data));
                    end
                end
            end

            if (byte_ch.valid && byte_ch.ready)
                scan_byte(byte_ch.data.source_byte);

            if (hold_left != 0)
            begin
                hold_left      <= hold_left - 1;
                token_ch.ready <= 1'b0;
            end
            else if (!hold_done && (tokens_checked >= HOLD_AFTER_TOKENS))
            begin
                hold_done      <= 1'b1;
                hold_left      <= HOLD_CYCLES;
                token_ch.ready <= 1'b0;
            end
            else
            begin
                token_ch.ready <= quiet || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;

        put_text("{\"a\":[7,true]}\n");
        src_bytes.push_back(CH_ZERO);
        put_text("false");
        src_bytes.push_back(CH_ZERO);
        put_text("\"x");
        src_bytes.push_back(CH_ZERO);
        put_text("9z");
        src_bytes.push_back(CH_ZERO);
        src_bytes.push_back(8'hFF);
        src_bytes.push_back(CH_ZERO);

        total_bytes = src_bytes.size() + RANDOM_BYTES;
        while (src_bytes.size() < total_bytes)
        begin
            if ($urandom_range(0, 99) < 80)
                put_document();
            else
                put_broken();
        end
        total_bytes = src_bytes.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent != total_bytes)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_tokens.size() != 0)
        begin
            mismatches += expected_tokens.size();
            $display("%0t: %0d expected token words never arrived", $time,
                expected_tokens.size());
        end

        $display("Sent %0d source bytes and checked %0d token words, %0d of them errors.",
            total_bytes, tokens_checked, scanner_errors);
        $display("Token kinds seen, one bit per kind: %b; the output was held off once.",
            kinds_seen);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
